/* src/ptmr_pkg.sv */
// ----------------------------------------------------------------------------
// ptmr_pkg
// Shared types and constants of the primality test unit.
// ----------------------------------------------------------------------------
package ptmr_pkg;

    localparam int SMALL_PRIME_COUNT = 54;
    localparam int BASE_FIELDS = 5;

    typedef struct packed {
        logic [4:0]  base_round4;
        logic [4:0]  base_round3;
        logic [4:0]  base_round2;
        logic [4:0]  base_round1;
        logic [4:0]  base_round0;
        logic [30:0] candidate;
    } t_in_word;

    typedef struct packed {
        logic [1:0] verdict;
        logic       probably_prime;
    } t_out_word;

    localparam logic [1:0] VERDICT_SMALL     = 2'd0;
    localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
    localparam logic [1:0] VERDICT_PRIME     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIAL,
        ST_TRIAL_WAIT,
        ST_DECOMP,
        ST_ROUND,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_CHECK,
        ST_SQUARE,
        ST_DONE
    } t_state;

    function automatic logic [7:0] small_prime(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd0: v = 8'd2;    6'd1: v = 8'd3;    6'd2: v = 8'd5;    6'd3: v = 8'd7;
            6'd4: v = 8'd11;   6'd5: v = 8'd13;   6'd6: v = 8'd17;   6'd7: v = 8'd19;
            6'd8: v = 8'd23;   6'd9: v = 8'd29;   6'd10: v = 8'd31;  6'd11: v = 8'd37;
            6'd12: v = 8'd41;  6'd13: v = 8'd43;  6'd14: v = 8'd47;  6'd15: v = 8'd53;
            6'd16: v = 8'd59;  6'd17: v = 8'd61;  6'd18: v = 8'd67;  6'd19: v = 8'd71;
            6'd20: v = 8'd73;  6'd21: v = 8'd79;  6'd22: v = 8'd83;  6'd23: v = 8'd89;
            6'd24: v = 8'd97;  6'd25: v = 8'd101; 6'd26: v = 8'd103; 6'd27: v = 8'd107;
            6'd28: v = 8'd109; 6'd29: v = 8'd113; 6'd30: v = 8'd127; 6'd31: v = 8'd131;
            6'd32: v = 8'd137; 6'd33: v = 8'd139; 6'd34: v = 8'd149; 6'd35: v = 8'd151;
            6'd36: v = 8'd157; 6'd37: v = 8'd163; 6'd38: v = 8'd167; 6'd39: v = 8'd173;
            6'd40: v = 8'd179; 6'd41: v = 8'd181; 6'd42: v = 8'd191; 6'd43: v = 8'd193;
            6'd44: v = 8'd197; 6'd45: v = 8'd199; 6'd46: v = 8'd211; 6'd47: v = 8'd223;
            6'd48: v = 8'd227; 6'd49: v = 8'd229; 6'd50: v = 8'd233; 6'd51: v = 8'd239;
            6'd52: v = 8'd241; 6'd53: v = 8'd251;
            default: v = 8'd2;
        endcase
        return v;
    endfunction

endpackage

/* src/ptmr_modmul.sv */
// ----------------------------------------------------------------------------
// ptmr_modmul
// Shared serial modular unit: computes (x * y) mod n one bit of y per cycle.
// With y equal to 1 it reduces x modulo n.
// ----------------------------------------------------------------------------
module ptmr_modmul import ptmr_pkg::*; #(
    parameter int W = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic [W-1:0] i_n,
    output logic         o_done,
    output logic [W-1:0] o_result
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;
    logic [W-1:0]  r_n;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W+1:0]  dbl, dbl_r, add, add_r;

    // Horner form from the top bit of y: acc = 2*acc (+ x), reduced each step.
    always_comb begin
        dbl   = {1'b0, r_acc, 1'b0};
        dbl_r = (dbl >= {2'b00, r_n}) ? dbl - {2'b00, r_n} : dbl;
        add   = dbl_r + (r_y[W-1] ? {2'b00, r_x} : '0);
        add_r = (add >= {2'b00, r_n}) ? add - {2'b00, r_n} : add;
        n_acc = add_r[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_acc  <= '0;
                r_y    <= i_y;
                r_n    <= i_n;
                // x below n is needed for one-step reduction; x may equal n only
                // when reducing, handled by the reduce of 2*acc + x.
                r_x    <= i_x;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_y   <= {r_y[W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

/* src/ptmr_trial.sv */
// ----------------------------------------------------------------------------
// ptmr_trial
// Serial remainder unit: reduces the candidate modulo one small prime,
// restoring division one bit per cycle.
// ----------------------------------------------------------------------------
module ptmr_trial import ptmr_pkg::*; #(
    parameter int W = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [7:0]   i_div,
    output logic         o_done,
    output logic         o_zero
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_num;
    logic [7:0]    r_rem;
    logic [7:0]    r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [8:0]    sh;

    assign sh = {r_rem, r_num[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_div  <= i_div;
                r_rem  <= '0;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_rem <= (sh >= {1'b0, r_div}) ? 8'(sh - {1'b0, r_div}) : sh[7:0];
                r_num <= {r_num[W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_zero = (r_rem == 8'd0);

endmodule

/* src/prime_test_trial_div_miller_rabin_unit.sv */
// ----------------------------------------------------------------------------
// prime_test_trial_div_miller_rabin_unit
// The candidate is trial-divided by up to 54 small primes, then each round takes
// about 2*log2(p) modular products on the shared serial unit.
// One word at a time: the next word is taken after the result is delivered.
// Synchronous active-low reset returns the sequencer to idle, output empty.
// ----------------------------------------------------------------------------
module prime_test_trial_div_miller_rabin_unit import ptmr_pkg::*; #(
    parameter int ROUNDS = 5,
    parameter int NUM_WIDTH = 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    localparam int W  = NUM_WIDTH;
    localparam int BW = $clog2(W + 1);
    localparam int RW = $clog2(ROUNDS + 1);

    t_state         r_state, n_state;
    logic [W-1:0]   r_p, r_m, r_e, r_z, r_x, r_r;
    logic [BW-1:0]  r_b, r_j;
    logic [5:0]     r_idx;
    logic [RW-1:0]  r_round;
    logic [2:0]     r_bsel;
    logic [24:0]    r_bases;
    logic [1:0]     r_verdict;
    logic           r_ovalid;
    logic           r_mul_sq;

    logic           tr_start, tr_done, tr_zero;
    logic           mm_start, mm_done;
    logic [W-1:0]   mm_x, mm_y, mm_res;
    logic [4:0]     base_raw;
    logic [W-1:0]   base_w, pm1;

    assign pm1 = r_p - 1'b1;

    always_comb begin
        case (r_bsel)
            3'd0: base_raw = r_bases[4:0];
            3'd1: base_raw = r_bases[9:5];
            3'd2: base_raw = r_bases[14:10];
            3'd3: base_raw = r_bases[19:15];
            default: base_raw = r_bases[24:20];
        endcase
        base_w = (base_raw == 5'd0 || base_raw == 5'd1) ? W'(2) : W'(base_raw);
    end

    ptmr_trial #(.W(W)) u_trial (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(tr_start),
        .i_num(r_p), .i_div(small_prime(r_idx)),
        .o_done(tr_done), .o_zero(tr_zero)
    );

    ptmr_modmul #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mm_start),
        .i_x(mm_x), .i_y(mm_y), .i_n(r_p),
        .o_done(mm_done), .o_result(mm_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:       if (i_valid && !r_ovalid) n_state = ST_TRIAL;
            ST_TRIAL:      n_state = ST_TRIAL_WAIT;
            ST_TRIAL_WAIT: begin
                if (tr_done) begin
                    if (tr_zero) n_state = ST_DONE;
                    else if (r_idx == 6'(SMALL_PRIME_COUNT - 1)) n_state = ST_DECOMP;
                    else n_state = ST_TRIAL;
                end
            end
            ST_DECOMP: begin
                if (r_p < W'(2)) n_state = ST_DONE;
                else if (r_m[0]) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_round == RW'(ROUNDS)) n_state = ST_DONE;
                else n_state = ST_POW_MUL;
            end
            ST_POW_MUL: begin
                if (r_e == '0) n_state = ST_CHECK;
                else if (mm_done) n_state = ST_POW_SQR;
            end
            ST_POW_SQR:    if (mm_done) n_state = ST_POW_MUL;
            ST_CHECK: begin
                if (r_r == W'(1) || r_r == pm1) begin
                    // Reached 1 or p-1: pass on either before any squaring, only on p-1 after squaring.
                    if (r_j == '0 || r_r == pm1) n_state = ST_ROUND;
                    else n_state = ST_DONE;
                end else if ((r_j + 1'b1) < r_b) begin
                    n_state = ST_SQUARE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SQUARE:     if (mm_done) n_state = ST_CHECK;
            ST_DONE:       n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        tr_start = (r_state == ST_TRIAL);
        mm_start = 1'b0;
        mm_x     = r_r;
        mm_y     = r_x;
        if (r_state == ST_POW_MUL && r_e != '0 && !r_mul_sq) begin
            mm_start = 1'b1;
            mm_y     = r_e[0] ? r_x : W'(1);
        end else if (r_state == ST_POW_SQR && !r_mul_sq) begin
            mm_start = 1'b1;
            mm_x     = r_x;
        end else if (r_state == ST_SQUARE && !r_mul_sq) begin
            mm_start = 1'b1;
            mm_y     = r_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_mul_sq <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mm_start) r_mul_sq <= 1'b1;
            else if (mm_done) r_mul_sq <= 1'b0;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_p     <= W'(i_data.candidate);
                        r_bases <= {i_data.base_round4, i_data.base_round3,
                                    i_data.base_round2, i_data.base_round1,
                                    i_data.base_round0};
                        r_idx   <= '0;
                    end
                end
                ST_TRIAL_WAIT: begin
                    if (tr_done) begin
                        r_idx <= r_idx + 1'b1;
                        r_verdict <= VERDICT_SMALL;
                        r_m <= r_p - 1'b1;
                        r_b <= '0;
                    end
                end
                ST_DECOMP: begin
                    r_verdict <= VERDICT_COMPOSITE;
                    r_round <= '0;
                    r_bsel <= '0;
                    if (r_p >= W'(2) && !r_m[0]) begin
                        r_m <= r_m >> 1;
                        r_b <= r_b + 1'b1;
                    end
                end
                ST_ROUND: begin
                    r_e <= r_m;
                    r_x <= base_w;
                    r_r <= W'(1);
                    r_j <= '0;
                    if (r_round == RW'(ROUNDS)) r_verdict <= VERDICT_PRIME;
                    r_round <= r_round + 1'b1;
                    r_bsel <= (r_bsel == 3'(BASE_FIELDS - 1)) ? 3'd0 : r_bsel + 1'b1;
                end
                ST_POW_MUL: if (mm_done) r_r <= mm_res;
                ST_POW_SQR: begin
                    if (mm_done) begin
                        r_x <= mm_res;
                        r_e <= r_e >> 1;
                    end
                end
                ST_CHECK: begin
                    if (!(r_r == W'(1) || r_r == pm1)) begin
                        r_j <= r_j + 1'b1;
                    end
                end
                ST_SQUARE: begin
                    if (mm_done) begin
                        r_r <= mm_res;
                        if (mm_res != W'(1) && mm_res != pm1 && r_j >= r_b) r_j <= r_j;
                    end
                end
                ST_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = '{verdict: r_verdict,
                       probably_prime: (r_verdict == VERDICT_PRIME)};

endmodule
